[hw/rtl/bdp_probe_estimator_core_assert.svh]
// Assertion macros shared by the estimator modules.
`ifndef BDP_PROBE_ESTIMATOR_CORE_ASSERT_SVH
`define BDP_PROBE_ESTIMATOR_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define BDP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define BDP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/bdp_pkg.sv]
`timescale 1ns / 1ps

package bdp_pkg;

    localparam int TIME_WIDTH_DEF  = 48;
    localparam int COUNT_WIDTH_DEF = 48;
    localparam int EST_W    = 48;
    localparam int BW_W     = 56;
    localparam int DELAY_W  = 14;
    localparam int OP_W     = 3;
    localparam int BYTES_W  = 32;
    localparam int JIT_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;
    // One million scaled product needs 20 extra bits.
    localparam int US_PER_S = 1000000;
    localparam int US_W     = 20;

    localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
    localparam logic [OP_W-1:0] OP_QUERY    = 3'd1;
    localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd2;
    localparam logic [OP_W-1:0] OP_START    = 3'd3;
    localparam logic [OP_W-1:0] OP_COMPLETE = 3'd4;
    localparam logic [OP_W-1:0] OP_RESTART  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_EST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP       = 3'd4;

    localparam logic [1:0] PH_UNSCHED = 2'd0;
    localparam logic [1:0] PH_SCHED   = 2'd1;
    localparam logic [1:0] PH_STARTED = 2'd2;

    // Request and reply between the control path and the serial units.
    typedef struct packed {
        logic start;
    } bdp_go_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bdp_stat_t;

endpackage

[hw/rtl/bdp_ser_mul.sv]
`timescale 1ns / 1ps

// Shift-add multiplier: one multiplier bit per cycle.
module bdp_ser_mul #(
    parameter int A_W = 48,
    parameter int B_W = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bdp_pkg::bdp_go_t     go,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output bdp_pkg::bdp_stat_t   stat,
    output logic [A_W+B_W-1:0]   p
);
    import bdp_pkg::*;

    localparam int CW = $clog2(B_W + 1);

    logic [A_W+B_W-1:0] acc_reg, acc_next, mc_reg, mc_next;
    logic [B_W-1:0]     mp_reg, mp_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next, done_reg, done_next;

    // Add the shifted multiplicand when the low multiplier bit is set.
    always_comb begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (go.start) begin
            acc_next  = '0;
            mc_next   = {{B_W{1'b0}}, a};
            mp_next   = b;
            cnt_next  = CW'(B_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (mp_reg[0]) acc_next = acc_reg + mc_reg;
            mc_next  = mc_reg << 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign p = acc_reg;
endmodule

[hw/rtl/bdp_ser_div.sv]
`timescale 1ns / 1ps

`include "bdp_probe_estimator_core_assert.svh"

// Restoring divider: one quotient bit per cycle, saturating result.
module bdp_ser_div #(
    parameter int N_W = 68,
    parameter int D_W = 48,
    parameter int Q_W = 56
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bdp_pkg::bdp_go_t     go,
    input  logic [N_W-1:0]       num,
    input  logic [D_W-1:0]       den,
    output bdp_pkg::bdp_stat_t   stat,
    output logic [Q_W-1:0]       q
);
    import bdp_pkg::*;

    localparam int CW = $clog2(N_W + 1);

    logic [N_W-1:0] n_reg, n_next, q_reg, q_next;
    logic [D_W:0]   r_reg, r_next, trial;
    logic [D_W-1:0] d_reg, d_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next, done_reg, done_next;

    assign trial = {r_reg[D_W-1:0], n_reg[N_W-1]};

    always_comb begin
        n_next = n_reg; q_next = q_reg; r_next = r_reg; d_next = d_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        if (go.start) begin
            n_next = num; q_next = '0; r_next = '0; d_next = den;
            cnt_next = CW'(N_W); busy_next = 1'b1;
        end else if (busy_reg) begin
            n_next = n_reg << 1;
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[N_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg <= n_next; q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign q = (|q_reg[N_W-1:Q_W]) ? {Q_W{1'b1}} : q_reg[Q_W-1:0];

    `BDP_ASSERT_NEXT(a_div_done_ends, aclk, aresetn, stat.done, !stat.done)
    `BDP_ASSERT_IMP(a_div_done_idle, aclk, aresetn, stat.done, !stat.busy)
    `BDP_ASSERT_IMP(a_div_rem_lt, aclk, aresetn, busy_reg && !go.start,
        r_reg < {1'b0, d_reg})
endmodule

[hw/rtl/bdp_probe_estimator_core.sv]
`timescale 1ns / 1ps

// Channel  | Ports                                   | Direction
// s_       | s_valid/s_ready, operation..jitter_ms   | in
// m_       | m_valid/m_ready, status..delay_ms       | out
// cfg_     | cfg_valid/cfg_ready, cfg_index/cfg_data | in
//
// Most operations are accepted, then their result is registered and held.
// A complete with a positive interval then runs 20 multiply steps by one
// million, a handoff to the divider, COUNT_WIDTH + 20 division steps
// and an update of the estimator state.
// Reset is synchronous, active low, and loads the register reset values.
// An item is taken only while no result waits, so m_ready stalls the input.

`include "bdp_probe_estimator_core_assert.svh"

module bdp_probe_estimator_core #(
    parameter int TIME_WIDTH  = bdp_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = bdp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bdp_pkg::OP_W-1:0]      s_operation,
    input  logic [bdp_pkg::BYTES_W-1:0]   s_byte_count,
    input  logic [47:0]                   s_now_us,
    input  logic [bdp_pkg::JIT_W-1:0]     s_jitter_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_status,
    output logic                          m_ping_due,
    output logic [bdp_pkg::EST_W-1:0]     m_window_estimate,
    output logic [bdp_pkg::BW_W-1:0]      m_bandwidth_estimate,
    output logic [bdp_pkg::DELAY_W-1:0]   m_delay_ms,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bdp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bdp_pkg::*;

    localparam int PW = COUNT_WIDTH + US_W;
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};
    localparam logic [TIME_WIDTH-1:0]  TMAX = {TIME_WIDTH{1'b1}};
    localparam logic [1:0] S_IDLE = 2'd0, S_MUL = 2'd1, S_DIV = 2'd2, S_OUT = 2'd3;

    // Configuration registers.
    logic [EST_W-1:0]   init_est_reg;
    logic [DELAY_W-1:0] init_delay_reg, ceiling_reg;
    logic [1:0]         thresh_reg;
    logic [9:0]         ramp_reg;

    // Estimator state.
    logic [1:0]             phase_reg;
    logic [COUNT_WIDTH-1:0] acc_reg;
    logic [EST_W-1:0]       est_reg;
    logic [BW_W-1:0]        bw_reg;
    logic [DELAY_W-1:0]     delay_reg;
    logic [1:0]             steady_reg;
    logic [TIME_WIDTH-1:0]  ptime_reg;

    logic [1:0] state_reg;
    logic [TIME_WIDTH-1:0] now_reg, dt_reg;
    logic [JIT_W-1:0] jit_reg;
    logic status_reg;

    logic [TIME_WIDTH-1:0] now_in;
    assign now_in = TIME_WIDTH'(s_now_us);

    bdp_go_t mul_go, div_go;
    bdp_stat_t mul_st, div_st;
    logic [PW-1:0] prod;
    logic [BW_W-1:0] quot;

    bdp_ser_mul #(.A_W(COUNT_WIDTH), .B_W(US_W)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .go(mul_go), .a(acc_reg),
        .b(US_W'(US_PER_S)), .stat(mul_st), .p(prod));

    bdp_ser_div #(.N_W(PW), .D_W(TIME_WIDTH), .Q_W(BW_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .go(div_go), .num(prod),
        .den(dt_reg), .stat(div_st), .q(quot));

    logic accept;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign m_valid   = (state_reg == S_OUT);
    assign mul_go.start = accept && s_operation == OP_COMPLETE
                          && phase_reg == PH_STARTED && now_in > ptime_reg;
    assign div_go.start = mul_st.done;

    // Completion update, applied with a measured bandwidth, or with zero when there is no measurement.
    logic [BW_W-1:0] bw_meas;
    logic [EST_W+1:0] two_est;
    logic [COUNT_WIDTH+1:0] acc_x3;
    logic [EST_W:0] dbl;
    logic [COUNT_WIDTH+EST_W:0] big, pick;
    logic grow;
    logic [TIME_WIDTH-1:0] now_use;
    logic [JIT_W-1:0] jit_use;
    logic [DELAY_W+1:0] ramp_sum;
    logic [DELAY_W-1:0] dnew;
    logic [2:0] steady_inc;
    logic [1:0] steady_new;
    logic [TIME_WIDTH+DELAY_W+10:0] tsum;
    logic [DELAY_W+9:0] ms;
    logic [1:0] state_next;

    // A complete without a measurement is applied at its accept and reads
    // the item itself; a measured one reads the copies latched at accept.
    assign now_use = (state_reg == S_IDLE) ? now_in : now_reg;
    assign jit_use = (state_reg == S_IDLE) ? s_jitter_ms : jit_reg;

    assign bw_meas  = (state_reg == S_DIV) ? quot : '0;
    assign two_est  = {1'b0, est_reg, 1'b0};
    // The count exceeds floor(2*est/3) exactly when 3*count exceeds 2*est.
    assign acc_x3   = {2'b0, acc_reg} + {1'b0, acc_reg, 1'b0};
    assign grow     = ({{EST_W{1'b0}}, acc_x3} > {{COUNT_WIDTH{1'b0}}, two_est})
                      && bw_meas > bw_reg;
    assign dbl      = {est_reg, 1'b0};
    assign big      = ({{EST_W+1{1'b0}}, acc_reg} > {{COUNT_WIDTH{1'b0}}, dbl})
                      ? {{EST_W+1{1'b0}}, acc_reg} : {{COUNT_WIDTH{1'b0}}, dbl};
    assign pick     = big;
    assign steady_inc = {1'b0, steady_reg} + ((steady_reg != 2'd3) ? 3'd1 : 3'd0);
    assign steady_new = steady_inc[1:0];
    assign ramp_sum = {2'b0, delay_reg} + {6'b0, ramp_reg} + {9'b0, jit_use};
    always_comb begin
        dnew = delay_reg;
        if (grow) dnew = delay_reg >> 1;
        else if (delay_reg < ceiling_reg && steady_new >= thresh_reg)
            dnew = (|ramp_sum[DELAY_W+1:DELAY_W]) ? {DELAY_W{1'b1}}
                                                  : ramp_sum[DELAY_W-1:0];
    end
    assign ms   = dnew * 10'd1000;
    assign tsum = {{DELAY_W+11{1'b0}}, now_use} + {{TIME_WIDTH+1{1'b0}}, ms};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = mul_go.start ? S_MUL : S_OUT;
            S_MUL:  if (mul_st.done) state_next = S_DIV;
            S_DIV:  if (div_st.done) state_next = S_OUT;
            S_OUT:  if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_est_reg <= EST_W'(65536); init_delay_reg <= DELAY_W'(100);
            ceiling_reg <= DELAY_W'(10000); thresh_reg <= 2'd2; ramp_reg <= 10'd100;
            state_reg <= S_IDLE; phase_reg <= PH_UNSCHED; acc_reg <= '0;
            est_reg <= EST_W'(65536); bw_reg <= '0; delay_reg <= DELAY_W'(100);
            steady_reg <= '0; ptime_reg <= '0; status_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_INIT_EST:   init_est_reg <= cfg_data[EST_W-1:0];
                    REG_INIT_DELAY: init_delay_reg <= cfg_data[DELAY_W-1:0];
                    REG_CEILING:    ceiling_reg <= cfg_data[DELAY_W-1:0];
                    REG_THRESHOLD:  thresh_reg <= cfg_data[1:0];
                    REG_RAMP:       ramp_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (accept) begin
                now_reg <= now_in; jit_reg <= s_jitter_ms;
                dt_reg <= now_in - ptime_reg;
                case (s_operation)
                    OP_ADD: begin
                        status_reg <= 1'b0;
                        acc_reg <= (acc_reg > CMAX - COUNT_WIDTH'(s_byte_count))
                            ? CMAX : acc_reg + COUNT_WIDTH'(s_byte_count);
                    end
                    OP_QUERY: status_reg <= 1'b0;
                    OP_SCHEDULE:
                        if (phase_reg != PH_UNSCHED) status_reg <= 1'b1;
                        else begin
                            status_reg <= 1'b0; phase_reg <= PH_SCHED; acc_reg <= '0;
                        end
                    OP_START:
                        if (phase_reg != PH_SCHED) status_reg <= 1'b1;
                        else begin
                            status_reg <= 1'b0;
                            phase_reg <= PH_STARTED; acc_reg <= '0; ptime_reg <= now_in;
                        end
                    OP_COMPLETE: status_reg <= (phase_reg != PH_STARTED);
                    OP_RESTART: begin
                        status_reg <= 1'b0;
                        phase_reg <= PH_UNSCHED; acc_reg <= '0; est_reg <= init_est_reg;
                        bw_reg <= '0; delay_reg <= init_delay_reg; steady_reg <= '0;
                        ptime_reg <= '0;
                    end
                    default: status_reg <= 1'b1;
                endcase
            end
            // Complete is applied at accept when there is no measurement, else once its bandwidth is known.
            if ((state_reg == S_IDLE && accept && s_operation == OP_COMPLETE
                 && phase_reg == PH_STARTED && !mul_go.start)
                || (state_reg == S_DIV && div_st.done)) begin
                if (grow) begin
                    est_reg <= (|pick[COUNT_WIDTH+EST_W:EST_W]) ? {EST_W{1'b1}}
                                                                 : pick[EST_W-1:0];
                    bw_reg <= bw_meas;
                end
                if (dnew != delay_reg) steady_reg <= '0;
                else if (!grow && delay_reg < ceiling_reg) steady_reg <= steady_new;
                delay_reg <= dnew;
                phase_reg <= PH_UNSCHED; acc_reg <= '0;
                ptime_reg <= (|tsum[TIME_WIDTH+DELAY_W+10:TIME_WIDTH]) ? TMAX
                                                                     : tsum[TIME_WIDTH-1:0];
            end
        end
    end

    assign m_status   = status_reg;
    assign m_ping_due = (phase_reg == PH_UNSCHED) && (now_reg >= ptime_reg);
    assign m_window_estimate    = est_reg;
    assign m_bandwidth_estimate = bw_reg;
    assign m_delay_ms = delay_reg;

    `BDP_ASSERT_IMP(a_no_take_busy, aclk, aresetn, mul_st.busy || div_st.busy, !s_ready)
    `BDP_ASSERT_IMP(a_out_idle_units, aclk, aresetn, m_valid,
        !mul_st.busy && !div_st.busy)
    `BDP_ASSERT_NEXT(a_mul_then_div, aclk, aresetn, mul_st.done, div_st.busy)
endmodule
